FILE: design/sdaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared types and constants of the signed decimal ascii formatter: channel
// payloads, controller/datapath command and status, character codes and the
// digit weight multiples used by the conversion step.
// ----------------------------------------------------------------------------
package sdaf_pkg;

   // input transaction payload
   typedef struct packed {
      logic signed [15:0] value;
      logic [2:0]         decimal_places;
   } req_payload_type;

   // result transaction payload
   typedef struct packed {
      logic [6:0] character;
      logic       last_char;
   } rsp_payload_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic conv;
      logic prep;
      logic emit_sign;
      logic emit_lead;
      logic emit_dot;
      logic emit_digit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic conv_done;
      logic is_neg;
      logic lead_zero;
      logic at_point;
      logic idx_last;
      logic out_free;
   } status_type;

   // ascii codes
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_DOT   = 7'h2E;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   // number of decimal places that still place a point
   localparam logic [2:0] MAX_PLACES = 3'd4;
   // digit positions: four weighted digits plus the units digit
   localparam logic [2:0] UNITS_POS  = 3'd4;
   localparam logic [2:0] NUM_POS    = 3'd5;
   localparam logic [1:0] LAST_WEIGHT = 2'd3;

   // multiples 0..9 of the weights 10000, 1000, 100 and 10
   localparam logic [16:0] MULT_TABLE [4][10] = '{
      '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
        17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
      '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
        17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
      '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
        17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
      '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
        17'd50, 17'd60, 17'd70, 17'd80, 17'd90}
   };

endpackage

FILE: design/sdaf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdaf_ctrl
// Controller of the formatter: accepts a transaction, steps the digit
// conversion and then sequences sign, leading zero, point and digits.
// ----------------------------------------------------------------------------
module sdaf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sdaf_pkg::status_type status,
   output sdaf_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CONV  = 6'b000010,
      ST_PREP  = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_LEAD  = 6'b010000,
      ST_DIGIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // only the idle state takes a new transaction
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            if (status.conv_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.is_neg) begin
               state_in = ST_SIGN;
            end else if (status.lead_zero) begin
               state_in = ST_LEAD;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in = status.lead_zero ? ST_LEAD : ST_DIGIT;
            end
         end
         ST_LEAD: begin
            if (status.out_free) begin
               cmd.emit_lead = 1'b1;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               if (status.at_point) begin
                  cmd.emit_dot = 1'b1;
               end else begin
                  cmd.emit_digit = 1'b1;
                  if (status.idx_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/sdaf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdaf_datapath
// Datapath of the formatter: magnitude and digit registers, one decimal
// digit per conversion step, point placement and the result register.
// ----------------------------------------------------------------------------
module sdaf_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sdaf_pkg::req_payload_type req_payload,
   input  sdaf_pkg::cmd_type         cmd,
   output sdaf_pkg::status_type      status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sdaf_pkg::rsp_payload_type rsp_payload
);

   logic [15:0] mag_ff, mag_in;
   logic [3:0]  digit_ff [4];
   logic [3:0]  digit_in;
   logic [1:0]  conv_idx_ff, conv_idx_in;
   logic [2:0]  places_ff, places_in;
   logic        neg_ff, neg_in;
   logic [2:0]  idx_ff, idx_in;
   logic        dot_done_ff, dot_done_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sdaf_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        has_point;
   logic [2:0]  point_pos;
   logic [2:0]  first_pos;
   logic [2:0]  start_pos;
   logic        out_free;
   logic [3:0]  cur_digit;

   // one decimal digit: largest multiple of the weight not above the magnitude
   always_comb begin
      digit_in = 4'd0;
      for (int m = 1; m < 10; m++) begin
         if ({1'b0, mag_ff} >= sdaf_pkg::MULT_TABLE[conv_idx_ff][m]) begin
            digit_in = 4'(m);
         end
      end
   end

   // first nonzero weighted digit, the units position if none
   always_comb begin
      first_pos = sdaf_pkg::UNITS_POS;
      for (int k = 3; k >= 0; k--) begin
         if (digit_ff[k] != 4'd0) begin
            first_pos = 3'(k);
         end
      end
   end

   // point placement
   assign has_point = (places_ff != 3'd0);
   assign point_pos = 3'(sdaf_pkg::NUM_POS - places_ff);
   assign start_pos = (has_point && (point_pos < first_pos)) ? point_pos : first_pos;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_digit = (idx_ff == sdaf_pkg::UNITS_POS) ? mag_ff[3:0] : digit_ff[idx_ff[1:0]];

   // status toward the controller
   always_comb begin
      status.conv_done = (conv_idx_ff == sdaf_pkg::LAST_WEIGHT);
      status.is_neg    = neg_ff;
      status.lead_zero = has_point && (first_pos >= point_pos);
      status.at_point  = has_point && (idx_ff == point_pos) && !dot_done_ff;
      status.idx_last  = (idx_ff == sdaf_pkg::UNITS_POS);
      status.out_free  = out_free;
   end

   // next values of the working registers
   always_comb begin
      mag_in      = mag_ff;
      conv_idx_in = conv_idx_ff;
      places_in   = places_ff;
      neg_in      = neg_ff;
      idx_in      = idx_ff;
      dot_done_in = dot_done_ff;
      if (cmd.load) begin
         neg_in      = req_payload.value[15];
         mag_in      = req_payload.value[15] ? 16'(16'd0 - req_payload.value)
                                             : req_payload.value;
         conv_idx_in = 2'd0;
         // a zero value or an out of range count prints no point
         if ((req_payload.decimal_places > sdaf_pkg::MAX_PLACES) ||
             (req_payload.value == 16'sd0)) begin
            places_in = 3'd0;
         end else begin
            places_in = req_payload.decimal_places;
         end
      end
      if (cmd.conv) begin
         mag_in      = 16'({1'b0, mag_ff} - sdaf_pkg::MULT_TABLE[conv_idx_ff][digit_in]);
         conv_idx_in = conv_idx_ff + 2'd1;
      end
      if (cmd.prep) begin
         idx_in      = start_pos;
         dot_done_in = 1'b0;
      end
      if (cmd.emit_dot) begin
         dot_done_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit_sign) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = sdaf_pkg::CHAR_MINUS;
         rsp_data_in.last_char = 1'b0;
      end
      if (cmd.emit_lead) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = sdaf_pkg::CHAR_ZERO;
         rsp_data_in.last_char = 1'b0;
      end
      if (cmd.emit_dot) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = sdaf_pkg::CHAR_DOT;
         rsp_data_in.last_char = 1'b0;
      end
      if (cmd.emit_digit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = sdaf_pkg::CHAR_ZERO + {3'd0, cur_digit};
         rsp_data_in.last_char = (idx_ff == sdaf_pkg::UNITS_POS);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      conv_idx_ff <= conv_idx_in;
      places_ff   <= places_in;
      neg_ff      <= neg_in;
      idx_ff      <= idx_in;
      dot_done_ff <= dot_done_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.conv) begin
         digit_ff[conv_idx_ff] <= digit_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: design/signed_decimal_ascii_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_core
// Prints a signed 16-bit value with 0 to 4 decimal places as ascii text,
// one character per result transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: value and decimal_places, taken when req_valid is high and
//   req_stall is low. req_stall is high while a number is being worked on.
//   rsp channel: one character per transaction, last_char marks the final
//   character of the number (1 to 7 characters per number).
// Sequence: the 4 conversion steps, the setup state and an emit state
//   come before the first character is registered; the rest follow one
//   per cycle while rsp_stall is low.
// Throughput: each number runs the one-digit-per-cycle conversion loop,
//   then one character per cycle through the single result register
//   while rsp_stall is low.
// Stalling: while rsp_stall is high the held character stays in the result
//   register and the sequence pauses; the next number can be taken while the
//   final character still waits.
// Reset: synchronous, clears the controller and the result valid; no
//   transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sdaf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sdaf_pkg::rsp_payload_type rsp_payload
);

   sdaf_pkg::cmd_type    cmd;
   sdaf_pkg::status_type status;

   // sequencing
   sdaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // conversion and result register
   sdaf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
